@@ design/button_click_press_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion shorthands used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define BCPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpc_pkg
// Types, codes and reset values for the button click / press classifier.
// ----------------------------------------------------------------------------
package bcpc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int BTN_IDX_W   = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICKS_REQ   = 2'd2;

  localparam logic [15:0] SHORT_LIMIT_RST  = 16'd500;
  localparam logic [15:0] WINDOW_LIMIT_RST = 16'd2000;
  localparam logic [3:0]  CLICKS_REQ_RST   = 4'd3;

  localparam logic [1:0] EDGE_NONE         = 2'd0;
  localparam logic [1:0] EDGE_PRESS        = 2'd1;
  localparam logic [1:0] EDGE_RELEASE      = 2'd2;
  localparam logic [1:0] EDGE_LONG_RELEASE = 2'd3;

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_CLICK = 2'd1;
  localparam logic [1:0] CLASS_SHORT = 2'd2;
  localparam logic [1:0] CLASS_LONG  = 2'd3;

  localparam logic [1:0] WIN_NONE    = 2'd0;
  localparam logic [1:0] WIN_SUCCESS = 2'd1;
  localparam logic [1:0] WIN_TIMEOUT = 2'd2;

  localparam logic [7:0] TALLY_MAX = 8'hFF;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] button_index;
    logic                 pin_level;
    logic [31:0]          now_ms;
  } poll_t;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] endpoint;
    logic [1:0]           edge_event;
    logic [1:0]           press_class;
    logic [1:0]           window_result;
    logic                 toggle_load;
    logic [1:0]           action_requests;
    logic [7:0]           clicks_so_far;
  } result_t;

  typedef struct packed {
    logic [31:0] press_stamp;
    logic [31:0] release_stamp;
    logic        idle_edge;
    logic        hold_armed;
    logic        release_pending;
    logic        waiting_release;
    logic        window_open;
    logic [7:0]  click_tally;
  } btn_state_t;

  typedef struct packed {
    logic [15:0] short_limit;
    logic [15:0] window_limit;
    logic [3:0]  clicks_req;
  } cfg_t;

  typedef struct packed {
    logic clear_others;
    logic load_window_start;
  } glob_upd_t;

  localparam btn_state_t BTN_RESET = '{
    press_stamp:     32'd0,
    release_stamp:   32'd0,
    idle_edge:       1'b1,
    hold_armed:      1'b0,
    release_pending: 1'b0,
    waiting_release: 1'b0,
    window_open:     1'b0,
    click_tally:     8'd0
  };

endpackage

@@ design/bcpc_eval.sv @@
// ----------------------------------------------------------------------------
// bcpc_eval
// One poll against one button's state: next state, result and shared updates.
// ----------------------------------------------------------------------------
module bcpc_eval import bcpc_pkg::*; (
  input  poll_t       poll,
  input  btn_state_t  cur,
  input  logic [31:0] window_start,
  input  cfg_t        cfg,
  output btn_state_t  nxt,
  output result_t     res,
  output glob_upd_t   upd
);

  logic        idx_ok;
  logic [31:0] dur;
  logic [31:0] held;
  logic [31:0] el;
  logic [31:0] ws_eff;
  logic [31:0] short32;
  logic [31:0] win32;

  assign idx_ok  = (32'(poll.button_index) < 32'(NUM_BUTTONS));
  assign short32 = {16'd0, cfg.short_limit};
  assign win32   = {16'd0, cfg.window_limit};

  always_comb begin
    nxt      = cur;
    res      = '0;
    res.endpoint = poll.button_index;
    upd      = '0;
    ws_eff   = window_start;
    dur      = nxt.release_stamp - nxt.press_stamp;
    held     = poll.now_ms - nxt.press_stamp;
    el       = '0;
    if (!idx_ok) begin
      nxt = cur;
    end else if (cur.waiting_release) begin
      if (poll.pin_level) begin
        nxt.waiting_release = 1'b0;
        nxt.hold_armed      = 1'b0;
        nxt.release_pending = 1'b0;
        nxt.idle_edge       = 1'b1;
        res.edge_event      = EDGE_LONG_RELEASE;
      end
      res.clicks_so_far = cur.click_tally;
    end else begin
      if (!poll.pin_level && cur.idle_edge) begin
        nxt.press_stamp = poll.now_ms;
        nxt.hold_armed  = 1'b1;
        nxt.idle_edge   = 1'b0;
        res.edge_event  = EDGE_PRESS;
      end else if (poll.pin_level && !cur.idle_edge) begin
        nxt.release_stamp   = poll.now_ms;
        nxt.idle_edge       = 1'b1;
        nxt.release_pending = 1'b1;
        nxt.hold_armed      = 1'b0;
        res.edge_event      = EDGE_RELEASE;
      end
      dur  = nxt.release_stamp - nxt.press_stamp;
      held = poll.now_ms - nxt.press_stamp;

      if (dur < short32 && nxt.release_pending) begin
        if (!nxt.window_open) begin
          upd.clear_others      = 1'b1;
          upd.load_window_start = 1'b1;
          nxt.click_tally       = 8'd0;
          nxt.window_open       = 1'b1;
          ws_eff                = poll.now_ms;
        end
        if (nxt.click_tally != TALLY_MAX) begin
          nxt.click_tally = nxt.click_tally + 8'd1;
        end
        nxt.release_pending = 1'b0;
        res.toggle_load     = 1'b1;
        res.press_class     = CLASS_CLICK;
      end else if (dur >= short32 && dur <= win32 && nxt.release_pending) begin
        nxt.release_pending = 1'b0;
        res.press_class     = CLASS_SHORT;
      end else if (held > win32 && nxt.hold_armed) begin
        res.action_requests = 2'd1;
        res.press_class     = CLASS_LONG;
        nxt.waiting_release = 1'b1;
      end

      el = poll.now_ms - ws_eff;
      if (nxt.click_tally != 8'd0 && nxt.window_open) begin
        if (el <= win32 && {4'd0, cfg.clicks_req} == nxt.click_tally) begin
          res.action_requests = res.action_requests + 2'd1;
          res.window_result   = WIN_SUCCESS;
          nxt.click_tally     = 8'd0;
          nxt.window_open     = 1'b0;
        end else if (el > win32) begin
          res.window_result = WIN_TIMEOUT;
          nxt.click_tally   = 8'd0;
          nxt.window_open   = 1'b0;
        end
      end
      res.clicks_so_far = nxt.click_tally;
    end
  end

endmodule

@@ design/button_click_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_click_press_classifier
// Classifies button polls into clicks, short and long presses and multi-click
// window outcomes; one result beat per poll beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_       input      in_valid/in_stall   poll_t   (index, level, now_ms)
//  out_      output     out_valid/out_stall result_t (one per poll)
//  cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (16 bits)
//
//  One poll per cycle unless out_stall; a poll registers in poll_r, then out_r.
//  Per-button state is read and written in the same cycle the result registers.
//  Reset restores all button state, window start and register defaults.
//  out_stall holds the result register and, once the input register is full,
//  raises in_stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "button_click_press_classifier_macros.svh"

module button_click_press_classifier import bcpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  poll_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  poll_t       poll_r;
  logic        s1_valid_r;
  result_t     out_r;
  logic        out_valid_r;
  btn_state_t  btn_r [NUM_BUTTONS];
  logic [31:0] window_start_r;
  cfg_t        cfg_r;

  btn_state_t  btn_nxt;
  result_t     res_nxt;
  glob_upd_t   upd;
  logic        adv;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  bcpc_eval u_eval (
    .poll         (poll_r),
    .cur          (btn_r[poll_r.button_index]),
    .window_start (window_start_r),
    .cfg          (cfg_r),
    .nxt          (btn_nxt),
    .res          (res_nxt),
    .upd          (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      window_start_r     <= 32'd0;
      cfg_r.short_limit  <= SHORT_LIMIT_RST;
      cfg_r.window_limit <= WINDOW_LIMIT_RST;
      cfg_r.clicks_req   <= CLICKS_REQ_RST;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        btn_r[k] <= BTN_RESET;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (in_valid && !in_stall) begin
        poll_r <= in_data;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv && s1_valid_r) begin
        out_r <= res_nxt;
        if (upd.load_window_start) begin
          window_start_r <= poll_r.now_ms;
        end
        for (int k = 0; k < NUM_BUTTONS; k++) begin
          if (BTN_IDX_W'(k) == poll_r.button_index) begin
            btn_r[k] <= btn_nxt;
          end else if (upd.clear_others) begin
            btn_r[k].window_open <= 1'b0;
            btn_r[k].click_tally <= 8'd0;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SHORT_LIMIT:  cfg_r.short_limit  <= cfg_data;
          CFG_WINDOW_LIMIT: cfg_r.window_limit <= cfg_data;
          CFG_CLICKS_REQ:   cfg_r.clicks_req   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  `BCPC_ASSERT_NEXT(a_advance_shows, s1_valid_r && adv, out_valid_r, "poll beat lost")
  `BCPC_ASSERT_NOW(a_toggle_is_click, out_valid_r && out_r.toggle_load,
                   out_r.press_class == CLASS_CLICK, "toggle without click")
  `BCPC_ASSERT_NOW(a_success_acts, out_valid_r && out_r.window_result == WIN_SUCCESS,
                   out_r.action_requests != 2'd0, "window success without action")
  `BCPC_ASSERT_NOW(a_wait_not_idle, btn_r[0].waiting_release,
                   !btn_r[0].idle_edge, "waiting for release while idle")

endmodule
